// File: design/dtip_pkg.sv
// Shared types and character constants for the decimal text parser.
// Used by every module of the parser; depends on nothing else.
package dtip_pkg;

    localparam int MAG_W = 31;
    localparam int VAL_W = 32;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_char_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] parsed_value;
        logic                    ok;
    } t_result;

endpackage

// File: design/dtip_in_stage.sv
// Input register of the parser: holds one character request until it is processed.
// Depends on dtip_pkg.
module dtip_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dtip_pkg::t_char_req i_req,
    output logic               o_stall,
    input  logic               i_fire,
    output logic               o_valid,
    output dtip_pkg::t_char_req o_req
);
    import dtip_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_char_req r_req;
    logic      accept;

    assign o_stall = r_valid && !i_fire;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// File: design/dtip_core.sv
// Parse state and the per-character update: sign, digit accumulate, error tracking.
// Depends on dtip_pkg.
module dtip_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  dtip_pkg::t_char_req i_req,
    output dtip_pkg::t_result   o_result
);
    import dtip_pkg::*;

    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic             r_first;
    logic             r_seen;
    logic             r_err;

    logic [MAG_W-1:0] n_mag;
    logic             n_neg;
    logic             n_seen;
    logic             n_err;

    logic             is_sign;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       char_off;
    logic [MAG_W+3:0] product;
    logic             ok;
    logic [VAL_W-1:0] mag_ext;

    always_comb begin
        is_sign  = r_first && ((i_req.char_code == CHAR_PLUS) ||
                               (i_req.char_code == CHAR_MINUS));
        is_digit = i_req.char_code inside {[CHAR_ZERO:CHAR_NINE]};
        char_off = i_req.char_code - CHAR_ZERO;
        digit    = char_off[3:0];
        product  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} +
                   {{MAG_W{1'b0}}, digit};

        n_mag  = r_mag;
        n_neg  = r_neg;
        n_seen = r_seen;
        n_err  = r_err;
        if (is_sign) begin
            n_neg = (i_req.char_code == CHAR_MINUS);
        end else if (is_digit) begin
            n_seen = 1'b1;
            if (product[MAG_W+3:MAG_W] != 4'd0) begin
                n_err = 1'b1;
            end else begin
                n_mag = product[MAG_W-1:0];
            end
        end else begin
            n_err = 1'b1;
        end
    end

    always_comb begin
        ok      = n_seen && !n_err;
        mag_ext = {1'b0, n_mag};
        o_result.ok = ok;
        if (!ok) begin
            o_result.parsed_value = '0;
        end else if (n_neg) begin
            o_result.parsed_value = -mag_ext;
        end else begin
            o_result.parsed_value = mag_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_first <= 1'b1;
            r_seen  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            if (i_req.is_last) begin
                r_mag   <= '0;
                r_neg   <= 1'b0;
                r_first <= 1'b1;
                r_seen  <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_first <= 1'b0;
                r_seen  <= n_seen;
                r_err   <= n_err;
            end
        end
    end

endmodule

// File: design/dtip_out_stage.sv
// Result register of the parser: holds one finished result until it is taken.
// Depends on dtip_pkg.
module dtip_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dtip_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output dtip_pkg::t_result o_result
);
    import dtip_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/decimal_text_to_int_parser.sv
// Signed decimal text to 32-bit integer parser, one character per request.
// The last character is registered in dtip_in_stage, its result in dtip_out_stage.
// One character per cycle (one accumulate step each) unless a held result stalls input.
// Reset is synchronous and active low; it clears all parse state and both valid flags.
// Depends on dtip_pkg, dtip_in_stage, dtip_core and dtip_out_stage.
module decimal_text_to_int_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_char_code,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [dtip_pkg::VAL_W-1:0] o_parsed_value,
    output logic                           o_ok
);
    import dtip_pkg::*;

    t_char_req in_req;
    t_char_req cur_req;
    t_result   core_result;
    t_result   out_result;
    logic      cur_valid;
    logic      out_free;
    logic      fire;
    logic      load;

    assign in_req.char_code = i_char_code;
    assign in_req.is_last   = i_is_last;

    assign fire = cur_valid && (!cur_req.is_last || out_free);
    assign load = fire && cur_req.is_last;

    dtip_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (in_req),
        .o_stall (o_in_stall),
        .i_fire  (fire),
        .o_valid (cur_valid),
        .o_req   (cur_req)
    );

    dtip_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (cur_req),
        .o_result (core_result)
    );

    dtip_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_parsed_value = out_result.parsed_value;
    assign o_ok           = out_result.ok;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_parsed_value == '0))
        else $error("failed result carries a nonzero value");

    a_no_min_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> (o_parsed_value != {1'b1, {(VAL_W-1){1'b0}}}))
        else $error("accepted result equals the most negative integer");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && cur_req.is_last))
        else $error("input stalled without a blocked result");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("finished string did not produce a result");
`endif

endmodule

// File: tb/sv/decimal_text_to_int_parser_tb.sv
// Self-checking testbench for decimal_text_to_int_parser: streams strings one character per
// request and predicts each signed value and ok flag. Depends on dtip_pkg and the parser RTL.
`timescale 1ns / 1ps

module decimal_text_to_int_parser_tb;
    import dtip_pkg::*;

    typedef logic [7:0] t_text[$];

    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;
    localparam logic [34:0] MAG_MAX = 35'd2147483647;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [7:0]              i_char_code = 8'h00;
    logic                    i_is_last = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_parsed_value;
    logic                    o_ok;

    logic [MAG_W-1:0] mag_acc;
    logic             neg_sign;
    logic             first_char;
    logic             digit_seen;
    logic             parse_error;

    t_result pending_values[$];
    int      fail_count = 0;
    int      chars_sent = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    int      tx_bursty = 0;
    int      rx_mode = 0;
    int      rx_run = 0;

    decimal_text_to_int_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_parsed_value (o_parsed_value),
        .o_ok           (o_ok)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_parse();
        mag_acc = '0;
        neg_sign = 1'b0;
        first_char = 1'b1;
        digit_seen = 1'b0;
        parse_error = 1'b0;
    endfunction

    function automatic void accumulate_char(logic [7:0] ch, logic last);
        logic [34:0] next_mag;
        t_result     res;
        if (first_char && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
            neg_sign = (ch == CHAR_MINUS);
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            next_mag = {4'b0, mag_acc} * 35'd10 + {27'b0, ch - CHAR_ZERO};
            digit_seen = 1'b1;
            if (next_mag > MAG_MAX) begin
                parse_error = 1'b1;
            end else begin
                mag_acc = next_mag[MAG_W-1:0];
            end
        end else begin
            parse_error = 1'b1;
        end
        first_char = 1'b0;
        if (last) begin
            res.ok = digit_seen && !parse_error;
            res.parsed_value = '0;
            if (res.ok) begin
                res.parsed_value = neg_sign ? -$signed({1'b0, mag_acc}) : $signed({1'b0, mag_acc});
            end
            pending_values.push_back(res);
            clear_parse();
        end
    endfunction

    // Results are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            clear_parse();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_values.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t ERROR: result with none expected, value %0d ok %0b",
                                 $time, o_parsed_value, o_ok);
                    end
                end else begin
                    exp_res = pending_values.pop_front();
                    if (o_parsed_value !== exp_res.parsed_value) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t ERROR: parsed_value expected %0d, actual %0d",
                                     $time, exp_res.parsed_value, o_parsed_value);
                        end
                    end
                    if (o_ok !== exp_res.ok) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t ERROR: ok expected %0b, actual %0b",
                                     $time, exp_res.ok, o_ok);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                accumulate_char(i_char_code, i_is_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_mode == 0) begin
            i_out_stall <= 1'b0;
            rx_run = 0;
        end else if (rx_run > 0) begin
            rx_run--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            rx_run = (rx_mode == 2) ? $urandom_range(0, 3) : $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b1;
            rx_run = (rx_mode == 2) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (tx_bursty != 0) begin
                gap = $urandom_range(0, 6);
            end
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_code <= ch;
        i_is_last <= last;
        do @(posedge i_clk); while (o_in_stall);
        chars_sent++;
    endtask

    task automatic send_text(input t_text text);
        foreach (text[i]) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    function automatic t_text to_text(string s);
        t_text text;
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        return text;
    endfunction

    task automatic send_str(input string s);
        send_text(to_text(s));
    endtask

    function automatic string random_number();
        string           s;
        string           sign;
        longint unsigned mag;
        int              kind;
        s = "";
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                mag = 64'($urandom_range(0, 999));
            end
            4, 5: begin
                mag = 64'($urandom());
            end
            6: begin
                mag = 64'($urandom_range(32'd2147483600, 32'd2147483647));
            end
            7: begin
                mag = 64'd2147483648 + 64'($urandom_range(0, 100));
            end
            8: begin
                mag = 0;
                repeat ($urandom_range(11, 22)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            default: begin
                mag = 64'($urandom_range(0, 99999999));
            end
        endcase
        if (kind != 8) begin
            s = $sformatf("%0d", mag);
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 25)) s = {"0", s};
        end
        case ($urandom_range(0, 2))
            0: sign = "";
            1: sign = "+";
            default: sign = "-";
        endcase
        return {sign, s};
    endfunction

    task automatic send_random_strings(input int char_budget);
        t_text text;
        int    stop_at;
        int    pick;
        stop_at = chars_sent + char_budget;
        while (chars_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            text = to_text(random_number());
            if (pick >= 17) begin
                text.delete();
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 3))
                        0: text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                        1: text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                        default: text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end else if (pick >= 14) begin
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_text(text);
        end
    endtask

    task automatic test_directed_values();
        tx_bursty = 0;
        rx_mode = 0;
        send_str("0");
        send_str("7");
        send_str("+0");
        send_str("-0");
        send_str("2147483647");
        send_str("+2147483647");
        send_str("-2147483647");
        send_str("-9");
        send_str("1234567890");
    endtask

    task automatic test_special_cases();
        t_text text;
        tx_bursty = 1;
        rx_mode = 1;
        // A lone sign has no digits.
        send_str("+");
        send_str("-");
        // Out of range, including the most negative 32-bit value.
        send_str("2147483648");
        send_str("-2147483648");
        send_str("21474836470");
        send_str("99999999999999999999999");
        // A sign after the first character, like any other non-digit, is an error.
        send_str("1-2");
        send_str("--5");
        send_str("+-");
        send_str("12a");
        send_str("/");
        send_str(":");
        send_str(",");
        send_str("*");
        // Leading zeros are taken however many there are.
        send_str("000000000000000000000000123");
        send_str("-00000000000000000000002147483647");
        text = '{8'hFF};
        send_text(text);
        text = '{CHAR_ZERO, 8'h00};
        send_text(text);
    endtask

    task automatic test_random_mixed();
        tx_bursty = 1;
        rx_mode = 1;
        send_random_strings(900);
    endtask

    task automatic test_back_to_back();
        tx_bursty = 0;
        rx_mode = 0;
        send_random_strings(300);
    endtask

    task automatic test_heavy_backpressure();
        tx_bursty = 1;
        rx_mode = 2;
        send_random_strings(350);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_values();
        test_special_cases();
        test_random_mixed();
        test_back_to_back();
        test_heavy_backpressure();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        rx_mode = 1;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
